[rtl/running_mean_variance_minmax_macros.svh]
// assertion macros for the running statistics block
// used by the checker file, expects clk and rst_n in the calling scope
`ifndef RUNNING_MEAN_VARIANCE_MINMAX_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_MINMAX_MACROS_SVH

// same-cycle implication, checked outside reset
`define RMVM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RMVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rmvm_pkg.sv]
// shared widths, request structs and controller/datapath command types
// for the running statistics block; no dependencies
package rmvm_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int COUNT_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int MEAN_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int PROD_BITS     = 2 * MEAN_BITS;
  localparam int SQ_BITS       = 51;
  localparam int VAR_BITS      = 36;
  localparam int SD_BITS       = 18;
  localparam int DIV_CNT_BITS  = $clog2(SQ_BITS + 1);
  localparam int SQRT_CNT_BITS = $clog2(SD_BITS + 1);

  typedef struct packed {
    logic                   restart;
    logic [SAMPLE_BITS-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  sample_count;
    logic [SAMPLE_BITS-1:0] min_code;
    logic [SAMPLE_BITS-1:0] max_code;
    logic [MEAN_BITS-1:0]   mean_fixed;
    logic [VAR_BITS-1:0]    variance_fixed;
    logic [SD_BITS-1:0]     std_dev_fixed;
    logic                   dropped;
  } out_req_t;

  typedef struct packed {
    logic load;
    logic mark_drop;
    logic first;
    logic step;
    logic mean_take;
    logic mul;
    logic acc;
    logic var_start;
    logic var_zero;
    logic var_take;
    logic sd_take;
    logic out_load;
  } rmvm_cmd_t;

  typedef struct packed {
    logic full;
    logic count_zero;
    logic count_gt1;
    logic div_done;
    logic sqrt_done;
  } rmvm_stat_t;

endpackage

[rtl/rmvm_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on rmvm_pkg
module rmvm_div import rmvm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SQ_BITS-1:0]      dividend,
  input  logic [COUNT_BITS-1:0]   divisor,
  input  logic [DIV_CNT_BITS-1:0] iters,
  output logic                    done,
  output logic [SQ_BITS-1:0]      quotient
);

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0]   rem_r;
  logic [COUNT_BITS-1:0]   dvs_r;
  logic [SQ_BITS-1:0]      dq_r;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     diff;
  logic                    ge;
  logic [COUNT_BITS-1:0]   rem_nxt;
  logic [SQ_BITS-1:0]      dq_nxt;

  assign trial   = {rem_r, dq_r[SQ_BITS-1]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign diff    = trial - {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  assign dq_nxt  = {dq_r[SQ_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dq_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

[rtl/rmvm_sqrt.sv]
// digit-by-digit integer square root, one root bit per cycle
// depends on rmvm_pkg
module rmvm_sqrt import rmvm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [VAR_BITS-1:0] radicand,
  output logic                done,
  output logic [SD_BITS-1:0]  root
);

  logic                     busy_r;
  logic                     done_r;
  logic [SQRT_CNT_BITS-1:0] cnt_r;
  logic [VAR_BITS-1:0]      rad_r;
  logic [SD_BITS+1:0]       rem_r;
  logic [SD_BITS-1:0]       root_r;
  logic [SD_BITS+3:0]       shifted;
  logic [SD_BITS+3:0]       trial;
  logic [SD_BITS+3:0]       diff;
  logic                     ge;
  logic [SD_BITS+1:0]       rem_nxt;
  logic [SD_BITS-1:0]       root_nxt;

  assign shifted  = {rem_r, rad_r[VAR_BITS-1 -: 2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign ge       = shifted >= trial;
  assign diff     = shifted - trial;
  assign rem_nxt  = ge ? diff[SD_BITS+1:0] : shifted[SD_BITS+1:0];
  assign root_nxt = {root_r[SD_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SQRT_CNT_BITS'(SD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - SQRT_CNT_BITS'(1);
        if (cnt_r == SQRT_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[VAR_BITS-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/rmvm_dp.sv]
// datapath: statistics registers, mean/variance arithmetic, output register
// depends on rmvm_pkg, rmvm_div and rmvm_sqrt
module rmvm_dp import rmvm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  in_req_t    in_data,
  input  rmvm_cmd_t  cmd,
  output rmvm_stat_t stat,
  output out_req_t   out_data
);

  logic [SAMPLE_BITS-1:0] x_r;
  logic [COUNT_BITS-1:0]  count_r;
  logic [SAMPLE_BITS-1:0] min_r;
  logic [SAMPLE_BITS-1:0] max_r;
  logic [MEAN_BITS-1:0]   mean_r;
  logic [SQ_BITS-1:0]     sq_r;
  logic                   dropped_r;
  logic                   up_r;
  logic [MEAN_BITS-1:0]   dmag_r;
  logic [MEAN_BITS-1:0]   rest_r;
  logic [PROD_BITS-1:0]   prod_r;
  logic [VAR_BITS-1:0]    var_r;
  logic [SD_BITS-1:0]     sd_r;
  out_req_t               out_r;

  logic [MEAN_BITS-1:0]    xf;
  logic                    up;
  logic [MEAN_BITS-1:0]    dmag;
  logic [COUNT_BITS-1:0]   count_inc;
  logic [COUNT_BITS-1:0]   count_dec;
  logic                    div_start;
  logic [SQ_BITS-1:0]      div_dividend;
  logic [COUNT_BITS-1:0]   div_divisor;
  logic [DIV_CNT_BITS-1:0] div_iters;
  logic                    div_done;
  logic [SQ_BITS-1:0]      div_quo;
  logic [MEAN_BITS-1:0]    mean_step;
  logic [MEAN_BITS-1:0]    mean_nxt;
  logic [MEAN_BITS-1:0]    rest_nxt;
  logic [VAR_BITS-1:0]     inc;
  logic [SQ_BITS:0]        sq_sum;
  logic [SQ_BITS-1:0]      sq_nxt;
  logic [VAR_BITS-1:0]     var_nxt;
  logic                    sqrt_done;
  logic [SD_BITS-1:0]      sqrt_root;

  assign xf        = {x_r, FRAC_BITS'(0)};
  assign up        = xf >= mean_r;
  assign dmag      = up ? (xf - mean_r) : (mean_r - xf);
  assign count_inc = count_r + COUNT_BITS'(1);
  assign count_dec = count_r - COUNT_BITS'(1);

  // shared divider: mean step (dividend left aligned) or variance
  assign div_start    = cmd.step | cmd.var_start;
  assign div_dividend = cmd.step ? {dmag, (SQ_BITS - MEAN_BITS)'(0)} : sq_r;
  assign div_divisor  = cmd.step ? count_inc : count_dec;
  assign div_iters    = cmd.step ? DIV_CNT_BITS'(MEAN_BITS) : DIV_CNT_BITS'(SQ_BITS);

  rmvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign mean_step = div_quo[MEAN_BITS-1:0];
  assign mean_nxt  = up_r ? (mean_r + mean_step) : (mean_r - mean_step);
  assign rest_nxt  = up_r ? (xf - mean_nxt) : (mean_nxt - xf);

  assign inc    = prod_r[PROD_BITS-1:FRAC_BITS];
  assign sq_sum = {1'b0, sq_r} + (SQ_BITS + 1)'(inc);
  assign sq_nxt = sq_sum[SQ_BITS] ? {SQ_BITS{1'b1}} : sq_sum[SQ_BITS-1:0];

  assign var_nxt = (|div_quo[SQ_BITS-1:VAR_BITS]) ? {VAR_BITS{1'b1}}
                                                  : div_quo[VAR_BITS-1:0];

  rmvm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.var_take),
    .radicand (var_nxt),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // running statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      mean_r  <= '0;
      sq_r    <= '0;
    end else begin
      if (cmd.load && in_data.restart) begin
        count_r <= '0;
      end
      if (cmd.first) begin
        count_r <= count_inc;
        min_r   <= x_r;
        max_r   <= x_r;
        mean_r  <= xf;
        sq_r    <= '0;
      end
      if (cmd.step) begin
        count_r <= count_inc;
        if (x_r < min_r) begin
          min_r <= x_r;
        end
        if (x_r > max_r) begin
          max_r <= x_r;
        end
      end
      if (cmd.mean_take) begin
        mean_r <= mean_nxt;
      end
      if (cmd.acc) begin
        sq_r <= sq_nxt;
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r       <= in_data.sample;
      dropped_r <= 1'b0;
    end
    if (cmd.mark_drop) begin
      dropped_r <= 1'b1;
    end
    if (cmd.step) begin
      up_r   <= up;
      dmag_r <= dmag;
    end
    if (cmd.mean_take) begin
      rest_r <= rest_nxt;
    end
    if (cmd.mul) begin
      prod_r <= PROD_BITS'(dmag_r) * PROD_BITS'(rest_r);
    end
    if (cmd.var_zero) begin
      var_r <= '0;
      sd_r  <= '0;
    end
    if (cmd.var_take) begin
      var_r <= var_nxt;
    end
    if (cmd.sd_take) begin
      sd_r <= sqrt_root;
    end
    if (cmd.out_load) begin
      out_r.sample_count   <= count_r;
      out_r.min_code       <= min_r;
      out_r.max_code       <= max_r;
      out_r.mean_fixed     <= mean_r;
      out_r.variance_fixed <= var_r;
      out_r.std_dev_fixed  <= sd_r;
      out_r.dropped        <= dropped_r;
    end
  end

  assign stat.full       = &count_r;
  assign stat.count_zero = count_r == '0;
  assign stat.count_gt1  = count_r > COUNT_BITS'(1);
  assign stat.div_done   = div_done;
  assign stat.sqrt_done  = sqrt_done;

  assign out_data = out_r;

endmodule

[rtl/rmvm_ctrl.sv]
// controller: sequences one request through the datapath, drives handshakes
// depends on rmvm_pkg
module rmvm_ctrl import rmvm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  rmvm_stat_t stat,
  output rmvm_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_DIVM  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_ACC   = 9'b000010000,
    S_VAR   = 9'b000100000,
    S_DIVV  = 9'b001000000,
    S_SQRT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.full) begin
          cmd.mark_drop = 1'b1;
          state_nxt     = S_VAR;
        end else if (stat.count_zero) begin
          cmd.first = 1'b1;
          state_nxt = S_VAR;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_DIVM;
        end
      end
      S_DIVM: begin
        if (stat.div_done) begin
          cmd.mean_take = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_VAR;
      end
      S_VAR: begin
        if (stat.count_gt1) begin
          cmd.var_start = 1'b1;
          state_nxt     = S_DIVV;
        end else begin
          cmd.var_zero = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DIVV: begin
        if (stat.div_done) begin
          cmd.var_take = 1'b1;
          state_nxt    = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.sd_take = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

[rtl/running_mean_variance_minmax.sv]
// channel | direction | payload  | handshake
// in_     | input     | in_req_t  | in_valid / in_stall
// out_    | output    | out_req_t | out_valid / out_stall
//
// an update request passes the mean step divide, the product and accumulate
// steps, the variance divide and the square root, all bit serial; a request
// that is dropped on a full count skips the mean step divide, product and
// accumulate, and a first sample runs none of the divides or the square root
// reset is synchronous, active low, and clears the statistics to zero
// a result waits in the output register under out_stall while the next request
// is taken and worked on; it stalls only in its last cycle if the register is full
//
// top level of the running statistics block, welford update in fixed point
// depends on rmvm_pkg, rmvm_ctrl and rmvm_dp
module running_mean_variance_minmax import rmvm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  // command and status between sequencer and datapath
  rmvm_cmd_t  cmd;
  rmvm_stat_t stat;

  // sequencer: one request at a time, from capture to output register
  rmvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: count, min, max, mean, squared deviation sum, shared divider,
  // square root unit and the output register
  rmvm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

[rtl/rmvm_chk.sv]
// port-level checker for the running statistics block, bound to the top level
// depends on rmvm_pkg and running_mean_variance_minmax_macros.svh
`include "running_mean_variance_minmax_macros.svh"

module rmvm_chk import rmvm_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_data
);

  // a taken request keeps the input closed while it is worked on
  `RMVM_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall, "input open after request")

  // a stalled result stays up and unchanged
  `RMVM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")

  `RMVM_ASSERT_IMPL(a_min_le_max, out_valid, out_data.min_code <= out_data.max_code, "min above max")

  // below two samples there is no spread
  `RMVM_ASSERT_IMPL(a_var_small, out_valid && (out_data.sample_count < COUNT_BITS'(2)), (out_data.variance_fixed == '0) && (out_data.std_dev_fixed == '0), "spread below two samples")

endmodule

bind running_mean_variance_minmax rmvm_chk u_rmvm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// self-checking bench for running_mean_variance_minmax: directed table plus random sample runs
// depends on rmvm_pkg and the running_mean_variance_minmax rtl
module tb_top;
  import rmvm_pkg::*;

  localparam int DIR_ROWS        = 22;
  localparam int RANDOM_ITEMS    = 900;
  localparam int CALM_ITEMS      = 100;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 200;
  localparam int MAX_PRINTS      = 200;

  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
  localparam longint unsigned SQ_MAX  = (64'd1 << SQ_BITS) - 64'd1;
  localparam longint unsigned VAR_MAX = (64'd1 << VAR_BITS) - 64'd1;

  // shape of the samples in one run between restarts
  typedef enum logic [1:0] {
    SPREAD_FULL,
    SPREAD_BAND,
    SPREAD_RAILS,
    SPREAD_FLAT
  } spread_t;

  // directed row; when typed is set the expected result is written out here,
  // and such rows always have zero variance, zero deviation and no drop
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   restart;
    logic                   typed;
    logic [COUNT_BITS-1:0]  count;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [MEAN_BITS-1:0]   mean;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_data;

  // shadow copy of the statistics kept by the block
  logic [COUNT_BITS-1:0]  stat_count;
  logic [SAMPLE_BITS-1:0] stat_min;
  logic [SAMPLE_BITS-1:0] stat_max;
  longint unsigned        stat_mean;
  longint unsigned        stat_sqsum;

  out_req_t stats_due [$];
  int       mismatches   = 0;
  int       results_seen = 0;
  bit       calm_tail    = 1'b0;
  bit       hold_off_req = 1'b0;
  int       send_idle_pct = 20;
  int       sink_idle_pct = 5;

  // first row comes right after reset without a restart flag
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{10'd0,    1'b0, 1'b1, 16'd1, 10'd0,    10'd0,    26'd0},
    '{10'd0,    1'b0, 1'b1, 16'd2, 10'd0,    10'd0,    26'd0},
    '{10'd1023, 1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd0,    1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd1023, 1'b1, 1'b1, 16'd1, 10'd1023, 10'd1023, 26'd67043328},
    '{10'd1023, 1'b0, 1'b1, 16'd2, 10'd1023, 10'd1023, 26'd67043328},
    '{10'd0,    1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd512,  1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd341,  1'b1, 1'b1, 16'd1, 10'd341,  10'd341,  26'd22347776},
    '{10'd682,  1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd1,    1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd1022, 1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd511,  1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd512,  1'b1, 1'b1, 16'd1, 10'd512,  10'd512,  26'd33554432},
    '{10'd513,  1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd511,  1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd512,  1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd700,  1'b1, 1'b1, 16'd1, 10'd700,  10'd700,  26'd45875200},
    '{10'd700,  1'b1, 1'b1, 16'd1, 10'd700,  10'd700,  26'd45875200},
    '{10'd3,    1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd1000, 1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0},
    '{10'd0,    1'b0, 1'b0, 16'd0, 10'd0,    10'd0,    26'd0}
  };

  running_mean_variance_minmax DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // welford step in fixed point: mean moves by the truncated share of the
  // deviation, the squared-deviation sum grows by d * (x - new mean)
  function automatic out_req_t welford_update(input in_req_t req);
    longint unsigned xf, dmag, mstep, newm, rest, inc, var_q, sd_q, trial;
    logic            up;
    out_req_t        res;
    if (req.restart) begin
      stat_count = '0;
      stat_min   = '0;
      stat_max   = '0;
      stat_mean  = 0;
      stat_sqsum = 0;
    end
    res.dropped = 1'b0;
    if (stat_count == COUNT_FULL) begin
      res.dropped = 1'b1;
    end else begin
      xf = 64'(req.sample) << FRAC_BITS;
      stat_count = stat_count + 1'b1;
      if (stat_count == 1) begin
        stat_min   = req.sample;
        stat_max   = req.sample;
        stat_mean  = xf;
        stat_sqsum = 0;
      end else begin
        up    = (xf >= stat_mean);
        dmag  = up ? xf - stat_mean : stat_mean - xf;
        mstep = dmag / stat_count;
        newm  = up ? stat_mean + mstep : stat_mean - mstep;
        rest  = up ? xf - newm : newm - xf;
        // both factors stay below 2^26, so the product fits in 64 bits
        inc   = (dmag * rest) >> FRAC_BITS;
        if (req.sample < stat_min) stat_min = req.sample;
        if (req.sample > stat_max) stat_max = req.sample;
        stat_mean = newm;
        if (inc > SQ_MAX - stat_sqsum) stat_sqsum = SQ_MAX;
        else stat_sqsum = stat_sqsum + inc;
      end
    end
    var_q = 0;
    if (stat_count > 1) begin
      var_q = stat_sqsum / (stat_count - 1'b1);
      if (var_q > VAR_MAX) var_q = VAR_MAX;
    end
    // integer square root, one result bit at a time from the top
    sd_q = 0;
    for (int b = SD_BITS - 1; b >= 0; b--) begin
      trial = sd_q | (64'd1 << b);
      if (trial * trial <= var_q) sd_q = trial;
    end
    res.sample_count   = stat_count;
    res.min_code       = stat_min;
    res.max_code       = stat_max;
    res.mean_fixed     = stat_mean[MEAN_BITS-1:0];
    res.variance_fixed = var_q[VAR_BITS-1:0];
    res.std_dev_fixed  = sd_q[SD_BITS-1:0];
    return res;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 5;
      default: return 20;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at result %0d, %s: got %0d, expected %0d", results_seen, what,
               got, want);
  endtask

  task automatic check_result(input out_req_t got);
    out_req_t want;
    if (stats_due.size() == 0) begin
      report_mismatch("result with no request pending", got.sample_count, 0);
    end else begin
      want = stats_due.pop_front();
      if (got.sample_count !== want.sample_count)
        report_mismatch("sample_count", got.sample_count, want.sample_count);
      if (got.min_code !== want.min_code)
        report_mismatch("min_code", got.min_code, want.min_code);
      if (got.max_code !== want.max_code)
        report_mismatch("max_code", got.max_code, want.max_code);
      if (got.mean_fixed !== want.mean_fixed)
        report_mismatch("mean_fixed", got.mean_fixed, want.mean_fixed);
      if (got.variance_fixed !== want.variance_fixed)
        report_mismatch("variance_fixed", got.variance_fixed, want.variance_fixed);
      if (got.std_dev_fixed !== want.std_dev_fixed)
        report_mismatch("std_dev_fixed", got.std_dev_fixed, want.std_dev_fixed);
      if (got.dropped !== want.dropped)
        report_mismatch("dropped", got.dropped, want.dropped);
    end
    results_seen++;
  endtask

  // result side: sampled at the rising edge, before the block updates anything
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // result stall generator; also runs the one long hold-off so the block backs up
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < sink_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) sink_idle_pct = pick_idle_pct();
    end
  end

  // offer one request, wait for it to be taken, then log what it should produce
  task automatic push_request(input in_req_t req, input bit typed, input out_req_t typed_exp);
    out_req_t predicted;
    @(negedge clk);
    if (!calm_tail && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predicted = welford_update(req);
    stats_due.push_back(typed ? typed_exp : predicted);
  endtask

  initial begin : stimulus
    in_req_t  req;
    out_req_t typed_exp;
    spread_t  spread;
    int       run_left;
    int       center;
    int       band_lo;
    int       band_hi;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    stat_count = '0;
    stat_min   = '0;
    stat_max   = '0;
    stat_mean  = 0;
    stat_sqsum = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed table: extremes, first sample with and without restart,
    // back-to-back restarts, mean moving both ways across the truncation
    foreach (dir_rows[i]) begin
      req.sample  = dir_rows[i].sample;
      req.restart = dir_rows[i].restart;
      typed_exp.sample_count   = dir_rows[i].count;
      typed_exp.min_code       = dir_rows[i].lo;
      typed_exp.max_code       = dir_rows[i].hi;
      typed_exp.mean_fixed     = dir_rows[i].mean;
      typed_exp.variance_fixed = '0;
      typed_exp.std_dev_fixed  = '0;
      typed_exp.dropped        = 1'b0;
      push_request(req, dir_rows[i].typed, typed_exp);
    end

    // long receiver hold-off right at the start of the random part
    hold_off_req = 1'b1;
    typed_exp    = '0;
    run_left     = 0;
    spread       = SPREAD_FULL;
    center       = 512;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
      if (n % 32 == 0) send_idle_pct = pick_idle_pct();
      if (run_left == 0) begin
        // new run: mostly short, now and then a long one to push the count up
        req.restart = 1'b1;
        run_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                  : $urandom_range(2, 40);
        spread      = spread_t'($urandom_range(0, 3));
        center      = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
      end else begin
        // stray restart in the middle of a run
        req.restart = ($urandom_range(0, 199) == 0);
      end
      run_left--;
      band_lo = (center < 8) ? 0 : center - 8;
      band_hi = (center > (1 << SAMPLE_BITS) - 9) ? (1 << SAMPLE_BITS) - 1 : center + 8;
      case (spread)
        SPREAD_FULL:  req.sample = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
        SPREAD_BAND:  req.sample = SAMPLE_BITS'($urandom_range(band_lo, band_hi));
        SPREAD_RAILS: req.sample = $urandom_range(0, 1) ? '1 : '0;
        default:      req.sample = SAMPLE_BITS'(center);
      endcase
      push_request(req, 1'b0, typed_exp);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    while (stats_due.size() != 0) @(posedge clk);
    // give a stray extra result time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rmvm_pkg.sv
rtl/rmvm_div.sv
rtl/rmvm_sqrt.sv
rtl/rmvm_dp.sv
rtl/rmvm_ctrl.sv
rtl/running_mean_variance_minmax.sv
rtl/rmvm_chk.sv
verif/tb_top.sv
